>>> rtl/tour_segment_reversal_unit_macros.svh
// Assertion macros for the tour segment reversal unit.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef TOUR_SEGMENT_REVERSAL_UNIT_MACROS_SVH
`define TOUR_SEGMENT_REVERSAL_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tsr_pkg.sv
// Shared constants, opcodes and controller/datapath interface structs
// for the tour segment reversal unit. No dependencies.
`default_nettype none

package tsr_pkg;

    localparam int MAX_CITIES = 1024;
    localparam int SLOT_W     = 10;          // slot, city and position width
    localparam int CNT_W      = SLOT_W + 1;  // city count register width

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_READ_SLOT = 2'd1,
        OP_READ_POS  = 2'd2,
        OP_REVERSE   = 2'd3
    } opcode_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // input transfer: latch operands
        logic load_wr;    // write both maps for a load
        logic rd_slot;    // read tour at start slot
        logic rd_pos;     // read position of city
        logic swap_rd_a;  // read tour at front pointer
        logic swap_rd_b;  // read tour at back pointer
        logic swap_wr_a;  // write back value to front slot
        logic swap_wr_b;  // write front value to back slot, step pointers
        logic pos_rd;     // read tour at rewrite pointer, step it
        logic resp_load;  // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        opcode_t op;
        logic    err;
        logic    swaps_zero;
        logic    swaps_last;
        logic    len_zero;
        logic    pos_last;
        logic    out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/tsr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tsr_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and register the read data; hold it while no read is issued
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/tsr_ctrl.sv
// Controller state machine of the tour segment reversal unit.
// Depends on tsr_pkg for the command and status structs.
`default_nettype none

module tsr_ctrl
    import tsr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DECODE   = 9'b000000010,
        ST_RD_WAIT  = 9'b000000100,
        ST_SWAP_RDA = 9'b000001000,
        ST_SWAP_RDB = 9'b000010000,
        ST_SWAP_WRA = 9'b000100000,
        ST_SWAP_WRB = 9'b001000000,
        ST_POS_RD   = 9'b010000000,
        ST_POS_DONE = 9'b100000000
    } state_t;

    // Finished result waiting for the output register, tracked beside the main state
    typedef enum logic [1:0] {
        RS_NONE = 2'b01,
        RS_WAIT = 2'b10
    } resp_t;

    state_t state_reg, state_next;
    resp_t  resp_reg, resp_next;

    // Advance the state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            resp_reg  <= RS_NONE;
        end else begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // Accept a new item only when no operation or result is pending
    assign s_ready = (state_reg == ST_IDLE) && (resp_reg == RS_NONE);

    always_comb begin
        state_next = state_reg;
        resp_next  = resp_reg;
        cmd        = '0;

        // Hand the finished result to the output register once it is free
        if (resp_reg == RS_WAIT && status.out_free) begin
            cmd.resp_load = 1'b1;
            resp_next     = RS_NONE;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.err) begin
                    resp_next  = RS_WAIT;
                    state_next = ST_IDLE;
                end else begin
                    unique case (status.op)
                        OP_LOAD: begin
                            cmd.load_wr = 1'b1;
                            resp_next   = RS_WAIT;
                            state_next  = ST_IDLE;
                        end
                        OP_READ_SLOT: begin
                            cmd.rd_slot = 1'b1;
                            state_next  = ST_RD_WAIT;
                        end
                        OP_READ_POS: begin
                            cmd.rd_pos = 1'b1;
                            state_next = ST_RD_WAIT;
                        end
                        OP_REVERSE: begin
                            priority if (status.len_zero) begin
                                resp_next  = RS_WAIT;
                                state_next = ST_IDLE;
                            end else if (status.swaps_zero) begin
                                state_next = ST_POS_RD;
                            end else begin
                                state_next = ST_SWAP_RDA;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                // Read data is registered in the RAM and holds until the next read
                resp_next  = RS_WAIT;
                state_next = ST_IDLE;
            end
            ST_SWAP_RDA: begin
                cmd.swap_rd_a = 1'b1;
                state_next    = ST_SWAP_RDB;
            end
            ST_SWAP_RDB: begin
                cmd.swap_rd_b = 1'b1;
                state_next    = ST_SWAP_WRA;
            end
            ST_SWAP_WRA: begin
                cmd.swap_wr_a = 1'b1;
                state_next    = ST_SWAP_WRB;
            end
            ST_SWAP_WRB: begin
                cmd.swap_wr_b = 1'b1;
                state_next    = status.swaps_last ? ST_POS_RD : ST_SWAP_RDA;
            end
            ST_POS_RD: begin
                cmd.pos_rd = 1'b1;
                if (status.pos_last) begin
                    state_next = ST_POS_DONE;
                end
            end
            ST_POS_DONE: begin
                // Last position write drains this cycle
                resp_next  = RS_WAIT;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tsr_dpath.sv
// Datapath of the tour segment reversal unit: operand registers, pointers,
// tour and position RAMs, result register. Depends on tsr_pkg and tsr_ram.
`default_nettype none

module tsr_dpath
    import tsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [SLOT_W-1:0] s_start_slot,
    input  wire logic [SLOT_W-1:0] s_end_slot,
    input  wire logic [SLOT_W-1:0] s_city_id,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output logic      [SLOT_W-1:0] m_city_out,
    output logic      [SLOT_W-1:0] m_position_out,
    output logic                   m_range_error
);

    logic [CNT_W-1:0]  city_count_reg;
    logic [CNT_W-1:0]  n_eff;
    opcode_t           in_op;
    logic              in_err;
    logic [CNT_W-1:0]  in_diff;
    logic [SLOT_W-1:0] in_len;
    logic [SLOT_W-1:0] in_last;

    opcode_t           op_reg;
    logic              err_reg;
    logic [SLOT_W-1:0] s_reg;
    logic [SLOT_W-1:0] c_reg;
    logic [SLOT_W-1:0] n_last_reg;
    logic [SLOT_W-1:0] a_reg, a_next;
    logic [SLOT_W-1:0] b_reg, b_next;
    logic [SLOT_W-1:0] p_reg, p_next;
    logic [SLOT_W-1:0] pprev_reg;
    logic [SLOT_W-1:0] swaps_reg;
    logic [SLOT_W-1:0] rem_reg;
    logic [SLOT_W-1:0] hold_reg;
    logic              pos_pend_reg;

    logic              tour_wr_en, tour_rd_en;
    logic [SLOT_W-1:0] tour_wr_addr, tour_wr_data, tour_rd_addr, tour_rd_data;
    logic              posm_wr_en;
    logic [SLOT_W-1:0] posm_wr_addr, posm_wr_data, posm_rd_data;

    logic              m_valid_reg;
    logic [SLOT_W-1:0] m_city_reg, m_pos_reg;
    logic              m_err_reg;

    // Hold the city count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            city_count_reg <= CNT_W'(MAX_CITIES);
        end else if (cfg_wr_en) begin
            city_count_reg <= cfg_wr_data;
        end
    end

    // Saturate the count at capacity
    assign n_eff = (city_count_reg > CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES)
                                                         : city_count_reg;
    assign in_op = opcode_t'(s_opcode);

    // Range check of the incoming operands
    always_comb begin
        unique case (in_op)
            OP_LOAD:      in_err = ({1'b0, s_start_slot} >= n_eff)
                                   || ({1'b0, s_city_id} >= n_eff);
            OP_READ_SLOT: in_err = ({1'b0, s_start_slot} >= n_eff);
            OP_READ_POS:  in_err = ({1'b0, s_city_id} >= n_eff);
            OP_REVERSE:   in_err = ({1'b0, s_start_slot} >= n_eff)
                                   || ({1'b0, s_end_slot} >= n_eff);
            default:      in_err = 1'b1;
        endcase
    end

    // Circular segment length and last slot of the segment
    assign in_diff = {1'b0, s_end_slot} - {1'b0, s_start_slot};
    assign in_len  = (s_end_slot >= s_start_slot) ? SLOT_W'(in_diff)
                                                  : SLOT_W'(in_diff + n_eff);
    assign in_last = (s_end_slot == '0) ? SLOT_W'(n_eff - CNT_W'(1))
                                        : s_end_slot - SLOT_W'(1);

    // Step pointers with wrap at the city count
    assign a_next = (a_reg == n_last_reg) ? '0 : a_reg + SLOT_W'(1);
    assign p_next = (p_reg == n_last_reg) ? '0 : p_reg + SLOT_W'(1);
    assign b_next = (b_reg == '0) ? n_last_reg : b_reg - SLOT_W'(1);

    // Latch operands and advance pointers and counters
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_op;
            err_reg    <= in_err;
            s_reg      <= s_start_slot;
            c_reg      <= s_city_id;
            n_last_reg <= SLOT_W'(n_eff - CNT_W'(1));
            a_reg      <= s_start_slot;
            b_reg      <= in_last;
            p_reg      <= s_start_slot;
            swaps_reg  <= in_len >> 1;
            rem_reg    <= in_len;
        end
        if (cmd.swap_rd_b) begin
            hold_reg <= tour_rd_data;
        end
        if (cmd.swap_wr_b) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            swaps_reg <= swaps_reg - SLOT_W'(1);
        end
        if (cmd.pos_rd) begin
            pprev_reg <= p_reg;
            p_reg     <= p_next;
            rem_reg   <= rem_reg - SLOT_W'(1);
        end
    end

    // Track a pending position write in the cycle after each rewrite-pass tour read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_pend_reg <= 1'b0;
        end else begin
            pos_pend_reg <= cmd.pos_rd;
        end
    end

    // Steer the tour RAM ports
    assign tour_wr_en = cmd.load_wr || cmd.swap_wr_a || cmd.swap_wr_b;
    assign tour_rd_en = cmd.rd_slot || cmd.swap_rd_a || cmd.swap_rd_b || cmd.pos_rd;

    always_comb begin
        priority if (cmd.load_wr) begin
            tour_wr_addr = s_reg;
            tour_wr_data = c_reg;
        end else if (cmd.swap_wr_a) begin
            tour_wr_addr = a_reg;
            tour_wr_data = tour_rd_data;
        end else begin
            tour_wr_addr = b_reg;
            tour_wr_data = hold_reg;
        end

        priority if (cmd.swap_rd_a) begin
            tour_rd_addr = a_reg;
        end else if (cmd.swap_rd_b) begin
            tour_rd_addr = b_reg;
        end else if (cmd.pos_rd) begin
            tour_rd_addr = p_reg;
        end else begin
            tour_rd_addr = s_reg;
        end
    end

    // Steer the position RAM write port
    assign posm_wr_en   = cmd.load_wr || pos_pend_reg;
    assign posm_wr_addr = cmd.load_wr ? c_reg : tour_rd_data;
    assign posm_wr_data = cmd.load_wr ? s_reg : pprev_reg;

    tsr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_CITIES)
    ) u_tour_ram (
        .aclk    (aclk),
        .wr_en   (tour_wr_en),
        .wr_addr (tour_wr_addr),
        .wr_data (tour_wr_data),
        .rd_en   (tour_rd_en),
        .rd_addr (tour_rd_addr),
        .rd_data (tour_rd_data)
    );

    tsr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_CITIES)
    ) u_pos_ram (
        .aclk    (aclk),
        .wr_en   (posm_wr_en),
        .wr_addr (posm_wr_addr),
        .wr_data (posm_wr_data),
        .rd_en   (cmd.rd_pos),
        .rd_addr (c_reg),
        .rd_data (posm_rd_data)
    );

    // Result register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.resp_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result register: payload, zero unless the operation read a value
    always_ff @(posedge aclk) begin
        if (cmd.resp_load) begin
            m_city_reg <= (op_reg == OP_READ_SLOT && !err_reg) ? tour_rd_data : '0;
            m_pos_reg  <= (op_reg == OP_READ_POS && !err_reg) ? posm_rd_data : '0;
            m_err_reg  <= err_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_city_out     = m_city_reg;
    assign m_position_out = m_pos_reg;
    assign m_range_error  = m_err_reg;

    // Report status to the controller
    assign status.op         = op_reg;
    assign status.err        = err_reg;
    assign status.swaps_zero = (swaps_reg == '0);
    assign status.swaps_last = (swaps_reg == SLOT_W'(1));
    assign status.len_zero   = (rem_reg == '0);
    assign status.pos_last   = (rem_reg == SLOT_W'(1));
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

>>> rtl/tour_segment_reversal_unit.sv
// Tour segment reversal unit, top level: controller plus datapath.
// Depends on tsr_pkg, tsr_ctrl, tsr_dpath and the assertion macro header.
//
// Keeps a circular tour (slot -> city) and its inverse (city -> position) in two
// 1024-entry RAMs with registered reads and handles one operation at a time.
// A reversal first swaps the two ends of the segment pair by pair: each swap
// costs two tour reads through the one tour read port and two tour writes.
// Then one pass over the segment rewrites the position map at one slot a
// cycle. The longest segment is 1023 slots at 1024 cities. The input is held
// off while an operation runs and while its result waits to enter the output
// register, which keeps a result until its transfer; the next input transfer
// can come once the result has entered that register. Entries never loaded
// read back undefined.
`default_nettype none
`include "tour_segment_reversal_unit_macros.svh"

module tour_segment_reversal_unit
    import tsr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_opcode,
    input  wire logic [SLOT_W-1:0] s_start_slot,
    input  wire logic [SLOT_W-1:0] s_end_slot,
    input  wire logic [SLOT_W-1:0] s_city_id,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [SLOT_W-1:0] m_city_out,
    output logic      [SLOT_W-1:0] m_position_out,
    output logic                   m_range_error
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [2:0] tour_wr_cmds;
    logic       err_data_zero;

    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tsr_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_opcode       (s_opcode),
        .s_start_slot   (s_start_slot),
        .s_end_slot     (s_end_slot),
        .s_city_id      (s_city_id),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_city_out     (m_city_out),
        .m_position_out (m_position_out),
        .m_range_error  (m_range_error)
    );

    assign tour_wr_cmds  = {cmd.load_wr, cmd.swap_wr_a, cmd.swap_wr_b};
    assign err_data_zero = (m_city_out == '0) && (m_position_out == '0);

    // Check one item in flight, exclusive tour writes, safe result load, zero error data
    `TSR_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "input taken while busy")
    `TSR_ASSERT_NOW(a_tour_wr_excl, 1'b1, $onehot0(tour_wr_cmds), "tour write conflict")
    `TSR_ASSERT_NOW(a_resp_free, cmd.resp_load, !m_valid || m_ready, "result overwritten")
    `TSR_ASSERT_NOW(a_err_zero, m_valid && m_range_error, err_data_zero, "error result has data")

endmodule

`default_nettype wire
